// ===== sv/pbhdma_pkg.sv =====
// Shared types and constants for the palette bank and HDMA register block.
package pbhdma_pkg;

    localparam int PalBytes = 64;
    localparam int PalIdxW  = 6;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_HBLANK = 2'd2;
    localparam logic [1:0] OP_SPEED  = 2'd3;

    localparam logic [7:0] A_KEY1  = 8'h4d;
    localparam logic [7:0] A_VBK   = 8'h4f;
    localparam logic [7:0] A_HDMA1 = 8'h51;
    localparam logic [7:0] A_HDMA2 = 8'h52;
    localparam logic [7:0] A_HDMA3 = 8'h53;
    localparam logic [7:0] A_HDMA4 = 8'h54;
    localparam logic [7:0] A_HDMA5 = 8'h55;
    localparam logic [7:0] A_BCPS  = 8'h68;
    localparam logic [7:0] A_BCPD  = 8'h69;
    localparam logic [7:0] A_OCPS  = 8'h6a;
    localparam logic [7:0] A_OCPD  = 8'h6b;
    localparam logic [7:0] A_SVBK  = 8'h70;

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [8:0] HBLANK_DOT  = 9'd252;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] scan_line;
        logic [8:0] line_dot;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  read_data;
        logic        xfer_valid;
        logic [15:0] xfer_source;
        logic [12:0] xfer_dest;
        logic [7:0]  xfer_blocks;
        logic        xfer_bank;
        logic [10:0] stall_cycles;
        logic        speed_switched;
        logic        vram_bank_out;
        logic [2:0]  wram_bank_out;
    } t_out;

    // Queue entry between the decode front and the execute back.
    typedef struct packed {
        t_in  item;
        logic en;
    } t_cmd;

endpackage

// ===== sv/palette_bank_hdma_registers.sv =====
// Top level of the palette bank and HDMA register block.
// A result passes through the front queue entry and then the back unit's result register.
// Throughput: one item per cycle while i_ready is high; the back unit's execute sets the rate.
// Reset is synchronous and active low; it clears the control and state registers (not the
// queue or result payloads) and both palettes (per-entry valid bits), so the block is ready once reset is released.
module palette_bank_hdma_registers (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  pbhdma_pkg::t_in     i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output pbhdma_pkg::t_out    o_item
);
    logic             r_color_mode;
    logic             q_valid, q_ready;
    pbhdma_pkg::t_cmd q_cmd;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_color_mode <= 1'b0;
        else if (i_cfg_we) r_color_mode <= i_cfg_data;
    end

    pbhdma_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .i_en(r_color_mode), .o_valid(q_valid), .i_ready(q_ready),
        .o_cmd(q_cmd)
    );

    pbhdma_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid(o_valid), .i_ready(i_ready), .o_res(o_item)
    );
endmodule

// ===== sv/pbhdma_front.sv =====
// Front part: accepts items, tags them with the enable bit and queues them.
module pbhdma_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pbhdma_pkg::t_in     i_item,
    input  logic                i_en,
    output logic                o_valid,
    input  logic                i_ready,
    output pbhdma_pkg::t_cmd    o_cmd
);
    // Two-entry queue; the back side pops in order.
    pbhdma_pkg::t_cmd r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{item: i_item, en: i_en};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("ready while full");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("pointer mismatch");
endmodule

// ===== sv/pbhdma_back.sv =====
// Back part: executes register accesses, DMA commands and speed switches.
module pbhdma_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pbhdma_pkg::t_cmd    i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output pbhdma_pkg::t_out    o_res
);
    logic [7:0]  r_bg_pal [pbhdma_pkg::PalBytes];
    logic [7:0]  r_obj_pal [pbhdma_pkg::PalBytes];
    logic [pbhdma_pkg::PalBytes-1:0] r_bg_vld, r_obj_vld;
    logic [7:0]  r_bg_rd, r_obj_rd;
    logic        r_dbl, r_arm, r_vbk;
    logic [2:0]  r_wsel;
    logic [7:0]  r_bgi, r_obji, r_last;
    logic [15:0] r_src;
    logic [12:0] r_dst;
    logic        r_act;
    logic [6:0]  r_rem;
    logic        r_ovld;
    pbhdma_pkg::t_out r_res;

    logic        n_dbl, n_arm, n_vbk, n_act;
    logic [2:0]  n_wsel;
    logic [7:0]  n_bgi, n_obji, n_last;
    logic [15:0] n_src;
    logic [12:0] n_dst;
    logic [6:0]  n_rem;
    pbhdma_pkg::t_out n_res;
    logic        fire, bg_we, obj_we;
    logic [pbhdma_pkg::PalIdxW-1:0] bg_a, obj_a, bg_na, obj_na;
    logic [7:0]  bg_rd, obj_rd, d, line;
    logic [8:0]  dot;
    logic [7:0]  blocks;
    logic [10:0] stall;
    logic        do_xfer;

    assign o_ready = !r_ovld || i_ready;
    assign fire    = i_valid && o_ready;
    assign o_valid = r_ovld;
    assign o_res   = r_res;
    assign bg_a    = r_bgi[pbhdma_pkg::PalIdxW-1:0];
    assign obj_a   = r_obji[pbhdma_pkg::PalIdxW-1:0];
    assign bg_na   = n_bgi[pbhdma_pkg::PalIdxW-1:0];
    assign obj_na  = n_obji[pbhdma_pkg::PalIdxW-1:0];
    assign bg_rd   = r_bg_rd;
    assign obj_rd  = r_obj_rd;
    assign d       = i_cmd.item.write_data;
    assign line    = i_cmd.item.scan_line;
    assign dot     = i_cmd.item.line_dot;

    // Execute one item against the current register state.
    always_comb begin
        n_dbl = r_dbl; n_arm = r_arm; n_vbk = r_vbk; n_wsel = r_wsel;
        n_bgi = r_bgi; n_obji = r_obji; n_last = r_last; n_src = r_src;
        n_dst = r_dst; n_act = r_act; n_rem = r_rem;
        n_res = '0;
        bg_we = 1'b0; obj_we = 1'b0;
        do_xfer = 1'b0; blocks = 8'd1; stall = r_dbl ? 11'd16 : 11'd8;
        if (i_cmd.en) begin
            case (i_cmd.item.op)
                pbhdma_pkg::OP_READ: begin
                    n_res.accepted = 1'b1;
                    case (i_cmd.item.reg_addr)
                        pbhdma_pkg::A_KEY1: n_res.read_data = {r_dbl, 6'h3f, r_arm};
                        pbhdma_pkg::A_VBK:  n_res.read_data = {7'h7f, r_vbk};
                        pbhdma_pkg::A_BCPS: n_res.read_data = r_bgi;
                        pbhdma_pkg::A_BCPD: n_res.read_data = bg_rd;
                        pbhdma_pkg::A_OCPS: n_res.read_data = r_obji;
                        pbhdma_pkg::A_OCPD: n_res.read_data = obj_rd;
                        pbhdma_pkg::A_SVBK: n_res.read_data = {5'h1f, r_wsel};
                        pbhdma_pkg::A_HDMA5: n_res.read_data = r_act ? {1'b0, r_rem} : 8'hff;
                        default: n_res.accepted = 1'b0;
                    endcase
                end
                pbhdma_pkg::OP_WRITE: begin
                    n_res.accepted = 1'b1;
                    case (i_cmd.item.reg_addr)
                        pbhdma_pkg::A_KEY1: n_arm = d[0];
                        pbhdma_pkg::A_VBK:  n_vbk = d[0];
                        pbhdma_pkg::A_BCPS: n_bgi = d;
                        pbhdma_pkg::A_BCPD: begin
                            bg_we = 1'b1;
                            if (r_bgi[7]) n_bgi = {2'b10, bg_a + 6'd1};
                        end
                        pbhdma_pkg::A_OCPS: n_obji = d;
                        pbhdma_pkg::A_OCPD: begin
                            obj_we = 1'b1;
                            if (r_obji[7]) n_obji = {2'b10, obj_a + 6'd1};
                        end
                        pbhdma_pkg::A_SVBK:  n_wsel = d[2:0];
                        pbhdma_pkg::A_HDMA1: n_src = {d, r_src[7:0]};
                        pbhdma_pkg::A_HDMA2: n_src = {r_src[15:8], d[7:4], 4'h0};
                        pbhdma_pkg::A_HDMA3: n_dst = {d[4:0], r_dst[7:0]};
                        pbhdma_pkg::A_HDMA4: n_dst = {r_dst[12:8], d[7:4], 4'h0};
                        pbhdma_pkg::A_HDMA5: begin
                            if (r_act && !d[7]) begin
                                n_act = 1'b0;
                            end else if (d[7]) begin
                                n_act = 1'b1;
                                n_rem = d[6:0];
                                if (line >= pbhdma_pkg::VBLANK_LINE) begin
                                    n_last = pbhdma_pkg::VBLANK_LINE - 8'd1;
                                end else if (dot >= pbhdma_pkg::HBLANK_DOT) begin
                                    do_xfer = 1'b1;
                                    n_last = line;
                                    if (d[6:0] == 7'd0) n_act = 1'b0;
                                    else n_rem = d[6:0] - 7'd1;
                                end else begin
                                    n_last = line - 8'd1;
                                end
                            end else begin
                                do_xfer = 1'b1;
                                blocks = {1'b0, d[6:0]} + 8'd1;
                                stall = {blocks, 3'b000};
                                n_act = 1'b0;
                            end
                        end
                        default: n_res.accepted = 1'b0;
                    endcase
                end
                pbhdma_pkg::OP_HBLANK: begin
                    if (r_act && line < pbhdma_pkg::VBLANK_LINE && line != r_last) begin
                        do_xfer = 1'b1;
                        n_last = line;
                        if (r_rem == 7'd0) n_act = 1'b0;
                        else n_rem = r_rem - 7'd1;
                    end
                end
                default: begin
                    if (r_arm) begin
                        n_dbl = ~r_dbl;
                        n_arm = 1'b0;
                        n_res.speed_switched = 1'b1;
                    end
                end
            endcase
        end
        if (do_xfer) begin
            n_res.xfer_valid   = 1'b1;
            n_res.xfer_source  = r_src;
            n_res.xfer_dest    = r_dst;
            n_res.xfer_blocks  = blocks;
            n_res.xfer_bank    = r_vbk;
            n_res.stall_cycles = stall;
            n_src = r_src + {4'h0, blocks, 4'h0};
            n_dst = r_dst + {1'b0, blocks, 4'h0};
        end
        n_res.vram_bank_out = n_vbk;
        n_res.wram_bank_out = (n_wsel == 3'd0) ? 3'd1 : n_wsel;
    end

    always_ff @(posedge i_clk) begin
        if (fire && bg_we) r_bg_pal[bg_a] <= d;
        if (fire && obj_we) r_obj_pal[obj_a] <= d;
        if (fire) r_res <= n_res;
        if (!i_rst_n) begin
            r_bg_vld <= '0; r_obj_vld <= '0;
            r_bg_rd <= 8'h00; r_obj_rd <= 8'h00;
            r_dbl <= 1'b0; r_arm <= 1'b0; r_vbk <= 1'b0; r_wsel <= 3'd1;
            r_bgi <= 8'd0; r_obji <= 8'd0; r_last <= 8'hff; r_src <= 16'd0;
            r_dst <= 13'd0; r_act <= 1'b0; r_rem <= 7'd0; r_ovld <= 1'b0;
        end else begin
            if (fire) begin
                if (bg_we) r_bg_vld[bg_a] <= 1'b1;
                if (obj_we) r_obj_vld[obj_a] <= 1'b1;
                // Registered palette read at the next index, with the byte written now
                // passed through when it lands on that index.
                if (bg_we && bg_na == bg_a) r_bg_rd <= d;
                else r_bg_rd <= r_bg_vld[bg_na] ? r_bg_pal[bg_na] : 8'h00;
                if (obj_we && obj_na == obj_a) r_obj_rd <= d;
                else r_obj_rd <= r_obj_vld[obj_na] ? r_obj_pal[obj_na] : 8'h00;
                r_dbl <= n_dbl; r_arm <= n_arm; r_vbk <= n_vbk; r_wsel <= n_wsel;
                r_bgi <= n_bgi; r_obji <= n_obji; r_last <= n_last; r_src <= n_src;
                r_dst <= n_dst; r_act <= n_act; r_rem <= n_rem;
            end
            if (fire) r_ovld <= 1'b1;
            else if (i_ready) r_ovld <= 1'b0;
        end
    end

    a_src_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && do_xfer |=> r_src[3:0] == $past(r_src[3:0]))
        else $error("source lost alignment");
    a_xfer_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_res.xfer_valid |-> r_res.xfer_blocks != 8'd0)
        else $error("empty transfer");
    a_wram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> r_res.wram_bank_out != 3'd0) else $error("bank zero shown");
endmodule

// ===== sim/tb_palette_bank_hdma_registers.sv =====
// Self-checking testbench for the palette bank and HDMA register block.
`timescale 1ns / 1ps

module tb_palette_bank_hdma_registers;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;
    logic i_valid;
    logic o_ready;
    pbhdma_pkg::t_in  i_item;
    logic o_valid;
    logic i_ready;
    pbhdma_pkg::t_out o_item;

    palette_bank_hdma_registers dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow copy of the register block state.
    logic       color_en;
    logic       speed_dbl;
    logic       arm_bit;
    logic       vbank;
    logic [2:0] wsel;
    logic [7:0] bg_idx;
    logic [7:0] obj_idx;
    logic [7:0] bg_pal [pbhdma_pkg::PalBytes];
    logic [7:0] obj_pal [pbhdma_pkg::PalBytes];
    logic [15:0] hdma_src;
    logic [12:0] hdma_dst;
    logic        hdma_on;
    logic [6:0]  hdma_left;
    logic [7:0]  line_done;

    pbhdma_pkg::t_out pending_results[$];
    int   mismatch_count;
    int   stall_mode;

    // Issue one transfer command and advance the addresses.
    function automatic void issue_xfer(inout pbhdma_pkg::t_out r, input int blocks,
                                       input int stall);
        r.xfer_valid   = 1'b1;
        r.xfer_source  = hdma_src;
        r.xfer_dest    = hdma_dst;
        r.xfer_blocks  = blocks[7:0];
        r.xfer_bank    = vbank;
        r.stall_cycles = stall[10:0];
        hdma_src = hdma_src + 16'(blocks * 16);
        hdma_dst = hdma_dst + 13'(blocks * 16);
    endfunction

    function automatic void hblank_chunk(inout pbhdma_pkg::t_out r);
        issue_xfer(r, 1, speed_dbl ? 16 : 8);
        if (hdma_left == 7'd0) hdma_on = 1'b0;
        else hdma_left = hdma_left - 7'd1;
    endfunction

    function automatic logic [7:0] bump_index(input logic [7:0] idx);
        return {idx[7], 1'b0, idx[5:0] + 6'd1};
    endfunction

    // Predict the result of one item and update the shadow state.
    function automatic pbhdma_pkg::t_out predict_regs(input pbhdma_pkg::t_in it);
        pbhdma_pkg::t_out r;
        r = '0;
        if (color_en) begin
            case (it.op)
                pbhdma_pkg::OP_READ: begin
                    r.accepted = 1'b1;
                    case (it.reg_addr)
                        pbhdma_pkg::A_KEY1:  r.read_data = {speed_dbl, 6'h3f, arm_bit};
                        pbhdma_pkg::A_VBK:   r.read_data = {7'h7f, vbank};
                        pbhdma_pkg::A_BCPS:  r.read_data = bg_idx;
                        pbhdma_pkg::A_BCPD:  r.read_data = bg_pal[bg_idx[5:0]];
                        pbhdma_pkg::A_OCPS:  r.read_data = obj_idx;
                        pbhdma_pkg::A_OCPD:  r.read_data = obj_pal[obj_idx[5:0]];
                        pbhdma_pkg::A_SVBK:  r.read_data = {5'h1f, wsel};
                        pbhdma_pkg::A_HDMA5: r.read_data = hdma_on ? {1'b0, hdma_left} : 8'hff;
                        default: r.accepted = 1'b0;
                    endcase
                end
                pbhdma_pkg::OP_WRITE: begin
                    r.accepted = 1'b1;
                    case (it.reg_addr)
                        pbhdma_pkg::A_KEY1: arm_bit = it.write_data[0];
                        pbhdma_pkg::A_VBK:  vbank = it.write_data[0];
                        pbhdma_pkg::A_BCPS: bg_idx = it.write_data;
                        pbhdma_pkg::A_BCPD: begin
                            bg_pal[bg_idx[5:0]] = it.write_data;
                            if (bg_idx[7]) bg_idx = bump_index(bg_idx);
                        end
                        pbhdma_pkg::A_OCPS: obj_idx = it.write_data;
                        pbhdma_pkg::A_OCPD: begin
                            obj_pal[obj_idx[5:0]] = it.write_data;
                            if (obj_idx[7]) obj_idx = bump_index(obj_idx);
                        end
                        pbhdma_pkg::A_SVBK:  wsel = it.write_data[2:0];
                        pbhdma_pkg::A_HDMA1: hdma_src[15:8] = it.write_data;
                        pbhdma_pkg::A_HDMA2: hdma_src[7:0] = {it.write_data[7:4], 4'h0};
                        pbhdma_pkg::A_HDMA3: hdma_dst[12:8] = it.write_data[4:0];
                        pbhdma_pkg::A_HDMA4: hdma_dst[7:0] = {it.write_data[7:4], 4'h0};
                        pbhdma_pkg::A_HDMA5: begin
                            if (hdma_on && !it.write_data[7]) begin
                                hdma_on = 1'b0;
                            end else if (it.write_data[7]) begin
                                hdma_on = 1'b1;
                                hdma_left = it.write_data[6:0];
                                if (it.scan_line >= pbhdma_pkg::VBLANK_LINE) begin
                                    line_done = 8'd143;
                                end else if (it.line_dot >= pbhdma_pkg::HBLANK_DOT) begin
                                    hblank_chunk(r);
                                    line_done = it.scan_line;
                                end else begin
                                    line_done = it.scan_line - 8'd1;
                                end
                            end else begin
                                issue_xfer(r, int'(it.write_data[6:0]) + 1,
                                           (int'(it.write_data[6:0]) + 1) * 8);
                                hdma_on = 1'b0;
                            end
                        end
                        default: r.accepted = 1'b0;
                    endcase
                end
                pbhdma_pkg::OP_HBLANK: begin
                    if (hdma_on && it.scan_line < pbhdma_pkg::VBLANK_LINE
                        && it.scan_line != line_done) begin
                        hblank_chunk(r);
                        line_done = it.scan_line;
                    end
                end
                default: begin
                    if (arm_bit) begin
                        speed_dbl = ~speed_dbl;
                        arm_bit = 1'b0;
                        r.speed_switched = 1'b1;
                    end
                end
            endcase
        end
        r.vram_bank_out = vbank;
        r.wram_bank_out = (wsel == 3'd0) ? 3'd1 : wsel;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item and record what it should produce; valid stays high for a
    // back-to-back follower and drops only over a gap.
    task automatic send_item(input pbhdma_pkg::t_in it);
        int g;
        g = (stall_mode == 0) ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_item  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_regs(it));
        @(negedge i_clk);
    endtask

    task automatic make_item(output pbhdma_pkg::t_in it, input logic [1:0] op,
                             input logic [7:0] a, input logic [7:0] d,
                             input logic [7:0] ln, input logic [8:0] dot);
        it.op = op;
        it.reg_addr = a;
        it.write_data = d;
        it.scan_line = ln;
        it.line_dot = dot;
    endtask

    task automatic send(input logic [1:0] op, input logic [7:0] a, input logic [7:0] d,
                        input logic [7:0] ln, input logic [8:0] dot);
        pbhdma_pkg::t_in it;
        make_item(it, op, a, d, ln, dot);
        send_item(it);
    endtask

    // Stop sending and wait for the expected-result queue to drain, at the falling edge.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_color_mode(input logic v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        color_en = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random backpressure when stall_mode is set, and field-by-field comparison.
    always @(negedge i_clk) begin
        if (stall_mode == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        pbhdma_pkg::t_out exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected result %h", o_item);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_item.accepted !== exp_r.accepted
                    || o_item.read_data !== exp_r.read_data
                    || o_item.xfer_valid !== exp_r.xfer_valid
                    || o_item.xfer_source !== exp_r.xfer_source
                    || o_item.xfer_dest !== exp_r.xfer_dest
                    || o_item.xfer_blocks !== exp_r.xfer_blocks
                    || o_item.xfer_bank !== exp_r.xfer_bank
                    || o_item.stall_cycles !== exp_r.stall_cycles
                    || o_item.speed_switched !== exp_r.speed_switched
                    || o_item.vram_bank_out !== exp_r.vram_bank_out
                    || o_item.wram_bank_out !== exp_r.wram_bank_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %h actual %h", exp_r, o_item);
                end
            end
        end
    end

    // Disabled block ignores every access.
    task automatic test_disabled();
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_VBK, 8'hff, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_KEY1, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA5, 8'h05, 8'd10, 9'd0);
        send(pbhdma_pkg::OP_SPEED, 8'h00, 8'h00, 8'd0, 9'd0);
    endtask

    // Directed extremes: every register, DMA cases, speed switch.
    task automatic test_directed();
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_KEY1, 8'hff, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_KEY1, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_SPEED, 8'h00, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_SPEED, 8'h00, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_SVBK, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_SVBK, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_VBK, 8'h01, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_BCPS, 8'hbf, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_BCPD, 8'ha5, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_BCPS, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_OCPS, 8'h7f, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_OCPD, 8'h5a, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_OCPD, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA1, 8'hff, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA2, 8'hff, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA3, 8'hff, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA4, 8'hff, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_HDMA1, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA5, 8'h7f, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA5, 8'h81, 8'd0, 9'd455);
        send(pbhdma_pkg::OP_HBLANK, 8'h00, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_HBLANK, 8'h00, 8'h00, 8'd1, 9'd0);
        send(pbhdma_pkg::OP_WRITE, pbhdma_pkg::A_HDMA5, 8'h80, 8'd153, 9'd0);
        send(pbhdma_pkg::OP_READ, pbhdma_pkg::A_HDMA5, 8'h00, 8'd0, 9'd0);
        send(pbhdma_pkg::OP_READ, 8'hff, 8'h00, 8'd0, 9'd0);
    endtask

    // Random items, mostly on the real registers, with some HBLANK items and lines past VBLANK.
    task automatic test_random(input int count);
        pbhdma_pkg::t_in it;
        logic [7:0] addrs [12];
        int p;
        addrs = '{pbhdma_pkg::A_KEY1, pbhdma_pkg::A_VBK, pbhdma_pkg::A_HDMA1,
                  pbhdma_pkg::A_HDMA2, pbhdma_pkg::A_HDMA3, pbhdma_pkg::A_HDMA4,
                  pbhdma_pkg::A_HDMA5, pbhdma_pkg::A_BCPS, pbhdma_pkg::A_BCPD,
                  pbhdma_pkg::A_OCPS, pbhdma_pkg::A_OCPD, pbhdma_pkg::A_SVBK};
        for (int i = 0; i < count; i++) begin
            it = pbhdma_pkg::t_in'(35'({$urandom, $urandom}));
            it.scan_line = 8'($urandom_range(0, 153));
            it.line_dot  = 9'($urandom_range(0, 455));
            p = $urandom_range(0, 99);
            if (p < 70) it.reg_addr = addrs[$urandom_range(0, 11)];
            if (p >= 70 && p < 85) it.op = pbhdma_pkg::OP_HBLANK;
            if (p >= 85 && p < 88) begin
                it.scan_line = 8'($urandom_range(144, 255));
            end
            send_item(it);
            if (i == count / 2) drain_results();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        mismatch_count = 0;
        stall_mode = 0;
        color_en = 1'b0; speed_dbl = 1'b0; arm_bit = 1'b0; vbank = 1'b0;
        wsel = 3'd1; bg_idx = '0; obj_idx = '0; hdma_src = '0; hdma_dst = '0;
        hdma_on = 1'b0; hdma_left = '0; line_done = 8'hff;
        for (int k = 0; k < pbhdma_pkg::PalBytes; k++) begin
            bg_pal[k] = '0;
            obj_pal[k] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_disabled();
        set_color_mode(1'b1);
        test_directed();
        stall_mode = 1;
        test_random(600);
        set_color_mode(1'b0);
        test_random(100);
        set_color_mode(1'b1);
        test_random(700);
        drain_results();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
